### rtl/core/hcfd_pkg.sv
// shared types and codes for the header-checked frame deframer
`timescale 1ns / 1ps

package hcfd_pkg;

	localparam int unsigned HDR_LEN   = 8;
	localparam int unsigned HDR_CNT_W = $clog2(HDR_LEN);
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// result kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// header error codes
	localparam logic [2:0] ERR_OK      = 3'd0;
	localparam logic [2:0] ERR_MAGIC   = 3'd1;
	localparam logic [2:0] ERR_VERSION = 3'd2;
	localparam logic [2:0] ERR_TYPE    = 3'd3;
	localparam logic [2:0] ERR_LENGTH  = 3'd4;

	// input operations
	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAGIC_FIRST  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAGIC_SECOND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VERSION      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TYPE_LOWEST  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TYPE_HIGHEST = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LIM  = 3'd5;

	typedef struct packed {
		logic [7:0]  magic_first;
		logic [7:0]  magic_second;
		logic [7:0]  protocol_version;
		logic [7:0]  type_lowest;
		logic [7:0]  type_highest;
		logic [15:0] payload_limit;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		magic_first:      8'd0,
		magic_second:     8'd0,
		protocol_version: 8'd1,
		type_lowest:      8'd0,
		type_highest:     8'd255,
		payload_limit:    16'd512
	};

	typedef struct packed {
		logic       op;
		logic [7:0] stream_byte;
	} item_t;

endpackage

### rtl/core/hcfd_if.sv
// stream channel interfaces for input bytes and results
`timescale 1ns / 1ps

interface hcfd_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] stream_byte;

	modport source (output valid, output op, output stream_byte, input ready);
	modport sink   (input valid, input op, input stream_byte, output ready);
endinterface

interface hcfd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  msg_type;
	logic [15:0] seq_number;
	logic [15:0] payload_length;
	logic [15:0] byte_index;
	logic [7:0]  payload_byte;
	logic        last;
	logic [2:0]  error_code;

	modport source (output valid, output kind, output msg_type, output seq_number,
		output payload_length, output byte_index, output payload_byte, output last,
		output error_code, input ready);
	modport sink   (input valid, input kind, input msg_type, input seq_number,
		input payload_length, input byte_index, input payload_byte, input last,
		input error_code, output ready);
endinterface

### rtl/core/hcfd_cfg_regs.sv
// configuration register bank
`timescale 1ns / 1ps

module hcfd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hcfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hcfd_pkg::CFG_DATA_W-1:0] cfg_data,
	output hcfd_pkg::cfg_t                 cfg
);
	import hcfd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAGIC_FIRST:  cfg_q.magic_first      <= cfg_data[7:0];
				REG_MAGIC_SECOND: cfg_q.magic_second     <= cfg_data[7:0];
				REG_VERSION:      cfg_q.protocol_version <= cfg_data[7:0];
				REG_TYPE_LOWEST:  cfg_q.type_lowest      <= cfg_data[7:0];
				REG_TYPE_HIGHEST: cfg_q.type_highest     <= cfg_data[7:0];
				REG_PAYLOAD_LIM:  cfg_q.payload_limit    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/hcfd_in_stage.sv
// input register stage
`timescale 1ns / 1ps

module hcfd_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	hcfd_in_if.sink         stream,
	output logic            valid_s1,
	output hcfd_pkg::item_t item_s1,
	input  logic            take
);
	import hcfd_pkg::*;

	logic valid_q;

	assign stream.ready = !valid_q || take;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (stream.ready) begin
			valid_q <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			item_s1.op          <= stream.op;
			item_s1.stream_byte <= stream.stream_byte;
		end
	end

endmodule

### rtl/core/hcfd_parser.sv
// header collection, header checks, payload tagging and result register
`timescale 1ns / 1ps

module hcfd_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  hcfd_pkg::cfg_t  cfg,
	input  logic            valid_s1,
	input  hcfd_pkg::item_t item_s1,
	output logic            take,
	hcfd_out_if.source      result
);
	import hcfd_pkg::*;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_ERROR   = 2'd2
	} phase_t;

	phase_t               phase_q, phase_d;
	logic [7:0]           hdr_q [HDR_LEN];
	logic [HDR_CNT_W-1:0] hdr_cnt_q, hdr_cnt_d;
	logic [15:0]          pay_cnt_q, pay_cnt_d;
	logic [15:0]          frame_len_q, frame_len_d;
	logic                 hdr_wr;

	logic        res_valid_q;
	logic        res_fire;
	logic [1:0]  res_kind;
	logic [7:0]  res_type;
	logic [15:0] res_seq;
	logic [15:0] res_len;
	logic [15:0] res_idx;
	logic [7:0]  res_byte;
	logic        res_last;
	logic [2:0]  res_err;

	logic [15:0] hdr_len;
	logic [2:0]  hdr_err;
	logic        pay_last;

	// s1 moves on whenever the result register is free or being drained
	assign take = !res_valid_q || result.ready;

	// eighth byte is the live input, the rest come from the store
	assign hdr_len = {hdr_q[4], hdr_q[5]};
	assign pay_last = ({1'b0, pay_cnt_q} + 17'd1) >= {1'b0, frame_len_q};

	always_comb begin
		if (hdr_q[0] != cfg.magic_first || hdr_q[1] != cfg.magic_second) begin
			hdr_err = ERR_MAGIC;
		end else if (hdr_q[2] != cfg.protocol_version) begin
			hdr_err = ERR_VERSION;
		end else if (hdr_q[3] < cfg.type_lowest || hdr_q[3] > cfg.type_highest) begin
			hdr_err = ERR_TYPE;
		end else if (hdr_len > cfg.payload_limit) begin
			hdr_err = ERR_LENGTH;
		end else begin
			hdr_err = ERR_OK;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		hdr_cnt_d   = hdr_cnt_q;
		pay_cnt_d   = pay_cnt_q;
		frame_len_d = frame_len_q;
		hdr_wr      = 1'b0;
		res_fire    = 1'b0;
		res_kind    = KIND_DATA;
		res_type    = 8'd0;
		res_seq     = 16'd0;
		res_len     = 16'd0;
		res_idx     = 16'd0;
		res_byte    = 8'd0;
		res_last    = 1'b0;
		res_err     = ERR_OK;
		if (item_s1.op == OP_CLEAR) begin
			phase_d   = PH_HEADER;
			hdr_cnt_d = '0;
			pay_cnt_d = 16'd0;
		end else begin
			case (phase_q)
				PH_HEADER: begin
					hdr_wr    = 1'b1;
					hdr_cnt_d = hdr_cnt_q + 1'b1;
					if (hdr_cnt_q == HDR_CNT_W'(HDR_LEN - 1)) begin
						if (hdr_err != ERR_OK) begin
							phase_d  = PH_ERROR;
							res_fire = 1'b1;
							res_kind = KIND_ERROR;
							res_err  = hdr_err;
						end else if (hdr_len == 16'd0) begin
							res_fire = 1'b1;
							res_kind = KIND_EMPTY;
							res_type = hdr_q[3];
							res_seq  = {hdr_q[6], item_s1.stream_byte};
							res_last = 1'b1;
						end else begin
							frame_len_d = hdr_len;
							pay_cnt_d   = 16'd0;
							phase_d     = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					res_fire = 1'b1;
					res_kind = KIND_DATA;
					res_type = hdr_q[3];
					res_seq  = {hdr_q[6], hdr_q[7]};
					res_len  = frame_len_q;
					res_idx  = pay_cnt_q;
					res_byte = item_s1.stream_byte;
					res_last = pay_last;
					if (pay_last) begin
						phase_d   = PH_HEADER;
						hdr_cnt_d = '0;
						pay_cnt_d = 16'd0;
					end else begin
						pay_cnt_d = pay_cnt_q + 16'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q               <= PH_HEADER;
			hdr_cnt_q             <= '0;
			pay_cnt_q             <= 16'd0;
			frame_len_q           <= 16'd0;
			res_valid_q           <= 1'b0;
			result.kind           <= KIND_DATA;
			result.msg_type       <= 8'd0;
			result.seq_number     <= 16'd0;
			result.payload_length <= 16'd0;
			result.byte_index     <= 16'd0;
			result.payload_byte   <= 8'd0;
			result.last           <= 1'b0;
			result.error_code     <= ERR_OK;
		end else if (take) begin
			res_valid_q <= valid_s1 && res_fire;
			if (valid_s1) begin
				phase_q     <= phase_d;
				hdr_cnt_q   <= hdr_cnt_d;
				pay_cnt_q   <= pay_cnt_d;
				frame_len_q <= frame_len_d;
				if (res_fire) begin
					result.kind           <= res_kind;
					result.msg_type       <= res_type;
					result.seq_number     <= res_seq;
					result.payload_length <= res_len;
					result.byte_index     <= res_idx;
					result.payload_byte   <= res_byte;
					result.last           <= res_last;
					result.error_code     <= res_err;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && valid_s1 && hdr_wr) begin
			hdr_q[hdr_cnt_q] <= item_s1.stream_byte;
		end
	end

	assign result.valid = res_valid_q;

endmodule

### rtl/core/header_checked_frame_deframer.sv
// top level of the header-checked frame deframer
//
//  channel   dir  handshake       payload
//  stream    in   valid / ready   op, stream_byte
//  result    out  valid / ready   kind, msg_type, seq_number, payload_length,
//                                 byte_index, payload_byte, last, error_code
//  cfg       in   cfg_we          cfg_index, cfg_data
//
// one transaction per cycle sustained while result.ready stays high; a result passes from
// its accepted byte through the input register, then the parser and result register
// the header check and payload tagging run in the single parser stage
// arst_n clears phase, counters, registers and valid flags; header store is not reset
// a stalled result holds both stages; stream.ready drops only when both are full
`timescale 1ns / 1ps

module header_checked_frame_deframer (
	input  logic                           clk,
	input  logic                           arst_n,
	hcfd_in_if.sink                        stream,
	hcfd_out_if.source                     result,
	input  logic                           cfg_we,
	input  logic [hcfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hcfd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import hcfd_pkg::*;

	cfg_t  cfg;
	logic  valid_s1;
	item_t item_s1;
	logic  take;

	hcfd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hcfd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take     (take)
	);

	hcfd_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take     (take),
		.result   (result)
	);

endmodule

### tb/deframer_checker.sv
// watches the deframer channels, predicts every result and compares it field by field
`timescale 1ns / 1ps

module deframer_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	hcfd_in_if                              stream,
	hcfd_out_if                             result,
	input  logic                            cfg_we,
	input  logic [hcfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hcfd_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatches,
	output int                              outstanding
);
	import hcfd_pkg::*;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_ERROR   = 2'd2
	} parse_phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  msg_type;
		logic [15:0] seq_number;
		logic [15:0] payload_length;
		logic [15:0] byte_index;
		logic [7:0]  payload_byte;
		logic        last;
		logic [2:0]  error_code;
	} frame_result_t;

	cfg_t          regs;
	parse_phase_t  phase;
	logic [7:0]    hdr [HDR_LEN];
	logic [3:0]    hdr_cnt;
	logic [15:0]   pay_cnt;
	logic [15:0]   frame_len;
	frame_result_t expected_results [$];

	task automatic report_mismatch(input string what);
		$display("%0t deframer mismatch: %s", $time, what);
		mismatches++;
	endtask

	// checks run in a fixed order, the first failing one wins
	function automatic logic [2:0] header_fault(input logic [15:0] len);
		if (hdr[0] != regs.magic_first || hdr[1] != regs.magic_second)
			return ERR_MAGIC;
		if (hdr[2] != regs.protocol_version)
			return ERR_VERSION;
		if (hdr[3] < regs.type_lowest || hdr[3] > regs.type_highest)
			return ERR_TYPE;
		if (len > regs.payload_limit)
			return ERR_LENGTH;
		return ERR_OK;
	endfunction

	task automatic deframe_item(input logic op, input logic [7:0] b);
		frame_result_t r;
		logic [15:0]   len;
		logic [2:0]    err;
		logic          fin;
		r = '0;
		if (op == OP_CLEAR) begin
			phase = PH_HEADER;
			hdr_cnt = '0;
			pay_cnt = '0;
		end else if (phase == PH_HEADER) begin
			hdr[hdr_cnt[2:0]] = b;
			hdr_cnt = hdr_cnt + 4'd1;
			if (hdr_cnt == 4'(HDR_LEN)) begin
				hdr_cnt = '0;
				len = {hdr[4], hdr[5]};
				err = header_fault(len);
				if (err != ERR_OK) begin
					phase = PH_ERROR;
					r.kind = KIND_ERROR;
					r.error_code = err;
					expected_results.push_back(r);
				end else if (len == 16'd0) begin
					r.kind = KIND_EMPTY;
					r.msg_type = hdr[3];
					r.seq_number = {hdr[6], hdr[7]};
					r.last = 1'b1;
					expected_results.push_back(r);
				end else begin
					frame_len = len;
					pay_cnt = '0;
					phase = PH_PAYLOAD;
				end
			end
		end else if (phase == PH_PAYLOAD) begin
			fin = ({1'b0, pay_cnt} + 17'd1) >= {1'b0, frame_len};
			r.kind = KIND_DATA;
			r.msg_type = hdr[3];
			r.seq_number = {hdr[6], hdr[7]};
			r.payload_length = frame_len;
			r.byte_index = pay_cnt;
			r.payload_byte = b;
			r.last = fin;
			expected_results.push_back(r);
			if (fin) begin
				phase = PH_HEADER;
				hdr_cnt = '0;
				pay_cnt = '0;
			end else begin
				pay_cnt = pay_cnt + 16'd1;
			end
		end
		// stuck in error: bytes are dropped until a clear
	endtask

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_MAGIC_FIRST:  regs.magic_first = val[7:0];
			REG_MAGIC_SECOND: regs.magic_second = val[7:0];
			REG_VERSION:      regs.protocol_version = val[7:0];
			REG_TYPE_LOWEST:  regs.type_lowest = val[7:0];
			REG_TYPE_HIGHEST: regs.type_highest = val[7:0];
			REG_PAYLOAD_LIM:  regs.payload_limit = val;
			default: ;
		endcase
	endtask

	task automatic compare_result(input frame_result_t got, input frame_result_t want);
		if (got.kind !== want.kind)
			report_mismatch($sformatf("kind got %0h expected %0h", got.kind, want.kind));
		if (got.msg_type !== want.msg_type)
			report_mismatch($sformatf("msg_type got %0h expected %0h",
				got.msg_type, want.msg_type));
		if (got.seq_number !== want.seq_number)
			report_mismatch($sformatf("seq_number got %0h expected %0h",
				got.seq_number, want.seq_number));
		if (got.payload_length !== want.payload_length)
			report_mismatch($sformatf("payload_length got %0h expected %0h",
				got.payload_length, want.payload_length));
		if (got.byte_index !== want.byte_index)
			report_mismatch($sformatf("byte_index got %0h expected %0h",
				got.byte_index, want.byte_index));
		if (got.payload_byte !== want.payload_byte)
			report_mismatch($sformatf("payload_byte got %0h expected %0h",
				got.payload_byte, want.payload_byte));
		if (got.last !== want.last)
			report_mismatch($sformatf("last got %0h expected %0h", got.last, want.last));
		if (got.error_code !== want.error_code)
			report_mismatch($sformatf("error_code got %0h expected %0h",
				got.error_code, want.error_code));
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		frame_result_t got;
		if (!arst_n) begin
			regs = CFG_RESET;
			phase = PH_HEADER;
			hdr_cnt = '0;
			pay_cnt = '0;
			frame_len = '0;
			expected_results.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we)
				apply_reg(cfg_index, cfg_data);
			if (stream.valid && stream.ready)
				deframe_item(stream.op, stream.stream_byte);
			if (result.valid && result.ready) begin
				got.kind = result.kind;
				got.msg_type = result.msg_type;
				got.seq_number = result.seq_number;
				got.payload_length = result.payload_length;
				got.byte_index = result.byte_index;
				got.payload_byte = result.payload_byte;
				got.last = result.last;
				got.error_code = result.error_code;
				if (expected_results.size() == 0)
					report_mismatch($sformatf("result transaction with nothing expected, kind %0h",
						got.kind));
				else
					compare_result(got, expected_results.pop_front());
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

### tb/header_checked_frame_deframer_tb.sv
// stimulus and verdict for the header-checked frame deframer
`timescale 1ns / 1ps

module header_checked_frame_deframer_tb;
	import hcfd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    outstanding;

	cfg_t live_cfg;
	bit   tx_burst;
	bit   rx_burst;
	bit   rx_hold;
	int   items_sent;

	hcfd_in_if  in_ch ();
	hcfd_out_if out_ch ();

	header_checked_frame_deframer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.stream    (in_ch),
		.result    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	deframer_checker frame_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.stream      (in_ch),
		.result      (out_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("header_checked_frame_deframer_tb: FAIL");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len(input bit burst);
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	initial begin : rx_side
		int n;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold) begin
				out_ch.ready <= 1'b0;
				repeat (150) @(posedge clk);
				rx_hold = 1'b0;
			end else begin
				n = idle_len(rx_burst);
				if (n > 0) begin
					out_ch.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
				out_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_item(input logic op, input logic [7:0] b, input bit tally);
		int n;
		in_ch.op <= op;
		in_ch.stream_byte <= b;
		in_ch.valid <= 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		if (tally)
			items_sent++;
		n = idle_len(tx_burst);
		if (n > 0) begin
			in_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_header(input logic [7:0] m0, input logic [7:0] m1, input logic [7:0] ver,
		input logic [7:0] typ, input logic [15:0] len, input logic [15:0] seq, input int count);
		logic [7:0] hb [HDR_LEN];
		hb = '{m0, m1, ver, typ, len[15:8], len[7:0], seq[15:8], seq[7:0]};
		for (int i = 0; i < count; i++)
			send_item(OP_BYTE, hb[i], 1'b1);
	endtask

	task automatic send_bytes(input int n, input bit tally);
		for (int i = 0; i < n; i++)
			send_item(OP_BYTE, 8'($urandom), tally);
	endtask

	task automatic send_clear();
		send_item(OP_CLEAR, 8'($urandom), 1'b1);
	endtask

	// drop valid and wait until every expected transaction has come back
	task automatic settle();
		int guard;
		in_ch.valid <= 1'b0;
		repeat (3) @(posedge clk);
		guard = 0;
		while (outstanding != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MAGIC_FIRST:  live_cfg.magic_first = val[7:0];
			REG_MAGIC_SECOND: live_cfg.magic_second = val[7:0];
			REG_VERSION:      live_cfg.protocol_version = val[7:0];
			REG_TYPE_LOWEST:  live_cfg.type_lowest = val[7:0];
			REG_TYPE_HIGHEST: live_cfg.type_highest = val[7:0];
			REG_PAYLOAD_LIM:  live_cfg.payload_limit = val;
			default: ;
		endcase
	endtask

	function automatic logic [15:0] pick_len(input logic [15:0] limit);
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 10 && limit <= 40)
			n = limit;
		else if (r < 50)
			n = $urandom_range(0, 4);
		else if (r < 90)
			n = $urandom_range(5, 20);
		else
			n = $urandom_range(21, 40);
		if (n > limit)
			n = limit;
		return 16'(n);
	endfunction

	task automatic random_frame();
		logic [7:0]  m0;
		logic [7:0]  m1;
		logic [7:0]  ver;
		logic [7:0]  typ;
		logic [15:0] len;
		logic [15:0] seq;
		int          pick;
		bit          range_ok;
		m0 = live_cfg.magic_first;
		m1 = live_cfg.magic_second;
		ver = live_cfg.protocol_version;
		range_ok = live_cfg.type_lowest <= live_cfg.type_highest;
		if (range_ok)
			typ = 8'($urandom_range(live_cfg.type_highest, live_cfg.type_lowest));
		else
			typ = 8'($urandom);
		seq = 16'($urandom);
		len = pick_len(live_cfg.payload_limit);
		pick = $urandom_range(0, 99);
		// with an empty type range no header can pass
		if (!range_ok)
			pick = 80;
		if (pick < 72) begin
			send_header(m0, m1, ver, typ, len, seq, HDR_LEN);
			send_bytes(len, 1'b1);
			if ($urandom_range(0, 19) == 0)
				send_clear();
		end else if (pick < 88) begin
			case ($urandom_range(0, 3))
				1: ver = ver ^ 8'($urandom_range(1, 255));
				2: begin
					if (live_cfg.type_lowest > 0)
						typ = 8'($urandom_range(live_cfg.type_lowest - 1, 0));
					else if (live_cfg.type_highest < 255)
						typ = 8'($urandom_range(255, live_cfg.type_highest + 1));
					else
						m1 = m1 ^ 8'(1 << $urandom_range(0, 7));
				end
				3: begin
					if (live_cfg.payload_limit < 16'hFFFF)
						len = live_cfg.payload_limit
							+ 16'($urandom_range(1, 65535 - live_cfg.payload_limit));
					else
						m0 = m0 ^ 8'(1 << $urandom_range(0, 7));
				end
				default: begin
					if ($urandom_range(0, 1))
						m0 = m0 ^ 8'(1 << $urandom_range(0, 7));
					else
						m1 = m1 ^ 8'(1 << $urandom_range(0, 7));
				end
			endcase
			send_header(m0, m1, ver, typ, len, seq, HDR_LEN);
			send_bytes($urandom_range(0, 3), 1'b0);
			send_clear();
		end else if (pick < 95) begin
			// frame cut short, either in the header or in the payload
			if (len >= 2 && $urandom_range(0, 1)) begin
				send_header(m0, m1, ver, typ, len, seq, HDR_LEN);
				send_bytes($urandom_range(1, len - 1), 1'b1);
			end else begin
				send_header(m0, m1, ver, typ, len, seq, $urandom_range(1, HDR_LEN - 1));
			end
			send_clear();
		end else begin
			send_bytes($urandom_range(1, 10), 1'b1);
			send_clear();
		end
	endtask

	task automatic random_run(input int upto);
		while (items_sent < upto) begin
			if ($urandom_range(0, 9) == 0)
				tx_burst = !tx_burst;
			if ($urandom_range(0, 9) == 0)
				rx_burst = !rx_burst;
			random_frame();
		end
		tx_burst = 1'b0;
		rx_burst = 1'b0;
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.op <= OP_BYTE;
		in_ch.stream_byte <= '0;
		live_cfg = CFG_RESET;
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		rx_hold = 1'b0;
		items_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty frame, one-byte frame with type and sequence at their maxima, bad version
		send_header(8'h00, 8'h00, 8'h01, 8'h00, 16'h0000, 16'h0000, HDR_LEN);
		send_header(8'h00, 8'h00, 8'h01, 8'hFF, 16'h0001, 16'hFFFF, HDR_LEN);
		send_item(OP_BYTE, 8'hFF, 1'b1);
		send_header(8'h00, 8'h00, 8'h02, 8'h10, 16'h0003, 16'h1234, HDR_LEN);
		send_item(OP_BYTE, 8'h55, 1'b0);
		send_clear();
		random_run(120);
		settle();

		set_reg(REG_MAGIC_FIRST, 16'h00A5);
		set_reg(REG_MAGIC_SECOND, 16'h005A);
		set_reg(REG_VERSION, 16'h0003);
		set_reg(REG_TYPE_LOWEST, 16'd10);
		set_reg(REG_TYPE_HIGHEST, 16'd20);
		set_reg(REG_PAYLOAD_LIM, 16'd32);
		// receiver stalls while a full-size frame is pushed in back to back
		tx_burst = 1'b1;
		rx_hold = 1'b1;
		send_header(8'hA5, 8'h5A, 8'h03, 8'd15, 16'd32, 16'($urandom), HDR_LEN);
		send_bytes(32, 1'b1);
		tx_burst = 1'b0;
		random_run(220);
		settle();

		set_reg(REG_MAGIC_FIRST, 16'h00FF);
		set_reg(REG_MAGIC_SECOND, 16'h00FF);
		set_reg(REG_VERSION, 16'h00FF);
		set_reg(REG_TYPE_HIGHEST, 16'd255);
		set_reg(REG_TYPE_LOWEST, 16'd255);
		set_reg(REG_PAYLOAD_LIM, 16'd0);
		set_reg(REG_SPARE_LO, 16'($urandom));
		set_reg(REG_SPARE_HI, 16'($urandom));
		random_run(270);
		settle();

		set_reg(REG_MAGIC_FIRST, 16'h0000);
		set_reg(REG_MAGIC_SECOND, 16'h0000);
		set_reg(REG_VERSION, 16'h0000);
		set_reg(REG_TYPE_LOWEST, 16'd200);
		set_reg(REG_TYPE_HIGHEST, 16'd100);
		set_reg(REG_PAYLOAD_LIM, 16'hFFFF);
		random_run(310);
		settle();

		set_reg(REG_MAGIC_FIRST, 16'($urandom_range(0, 255)));
		set_reg(REG_MAGIC_SECOND, 16'($urandom_range(0, 255)));
		set_reg(REG_VERSION, 16'($urandom_range(0, 255)));
		set_reg(REG_TYPE_LOWEST, 16'd0);
		set_reg(REG_TYPE_HIGHEST, 16'd255);
		// a frame of the largest length, streamed without gaps and then cut short
		tx_burst = 1'b1;
		rx_burst = 1'b1;
		send_header(live_cfg.magic_first, live_cfg.magic_second, live_cfg.protocol_version,
			8'($urandom), 16'hFFFF, 16'($urandom), HDR_LEN);
		send_bytes(40, 1'b1);
		send_clear();
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		random_run(400);
		settle();

		if (mismatches == 0 && outstanding == 0)
			$display("header_checked_frame_deframer_tb: PASS");
		else
			$display("header_checked_frame_deframer_tb: FAIL");
		$finish;
	end

endmodule

### filelist.f
rtl/core/hcfd_pkg.sv
rtl/core/hcfd_if.sv
rtl/core/hcfd_cfg_regs.sv
rtl/core/hcfd_in_stage.sv
rtl/core/hcfd_parser.sv
rtl/core/header_checked_frame_deframer.sv
tb/deframer_checker.sv
tb/header_checked_frame_deframer_tb.sv
